>>> design/region_thread_count_search_core_defines.svh
// Assertion helpers for the region thread count search block
`ifndef REGION_THREAD_COUNT_SEARCH_CORE_DEFINES_SVH
`define REGION_THREAD_COUNT_SEARCH_CORE_DEFINES_SVH

// same-cycle implication
`define RTCS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RTCS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/rtcs_pkg.sv
package rtcs_pkg;

  localparam int CORE_BITS     = 9;
  localparam int DEFAULT_SLOTS = 64;
  localparam logic [CORE_BITS-1:0] TMAX = '1;

  typedef logic [CORE_BITS-1:0] thr_t;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_REPEAT = 3'd1,
    PH_S0     = 3'd2,
    PH_S1     = 3'd3,
    PH_S2     = 3'd4,
    PH_ENDT   = 3'd5,
    PH_END    = 3'd6,
    PH_SPARE  = 3'd7
  } phase_t;

  localparam logic [7:0] REG_CORE_COUNT  = 8'd0;
  localparam logic [7:0] REG_START       = 8'd1;
  localparam logic [7:0] REG_METRIC      = 8'd2;
  localparam logic [7:0] REG_THRESHOLD   = 8'd3;

  localparam thr_t        RST_CORE_COUNT = 9'd8;
  localparam thr_t        RST_START      = 9'd2;
  localparam logic [31:0] RST_THRESHOLD  = 32'd740;

  typedef struct packed {
    phase_t      phase;
    logic        metric;
    thr_t        trial;
    thr_t        prev;
    thr_t        best;
    thr_t        step;
    logic [63:0] score;
    logic        boost;
    logic [31:0] toff;
    logic [31:0] ton;
  } rec_t;

  function automatic thr_t sat_thr(input logic [CORE_BITS:0] v);
    sat_thr = (v > {1'b0, TMAX}) ? TMAX : v[CORE_BITS-1:0];
  endfunction

endpackage

>>> design/region_thread_count_search_core.sv
// Region thread count search.
// Input channel (in_valid/in_ready): one request per region entry, carrying
// region_key and the time and energy of the region run just before.
// Output channel (out_valid/out_ready): exactly one result per request with
// the thread count for the entered region, its table slot, boost write
// requests and the table full flag.
// Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index picks
// core_count, start_threads, metric_mode or switch_threshold; write only idle.
// The key lookup walks the key memory, reading and comparing each stored
// region in turn; then come record read, multiply, update and write-back
// in the record memory. One request is in flight at a time; the next
// is taken while a finished result still waits in the output register.
// Reset clears region count, previous region and the configuration to
// defaults; memories need no clearing since slots are initialized when
// claimed. A stalled receiver holds the result and, once a second result
// is ready, holds the block in its final state.
module region_thread_count_search_core
  import rtcs_pkg::*;
#(
  parameter int REGION_SLOTS = DEFAULT_SLOTS,
  localparam int SW = $clog2(REGION_SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       region_key,
  input  logic [31:0]       elapsed_time,
  input  logic [31:0]       elapsed_energy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CORE_BITS-1:0] thread_count,
  output logic [SW-1:0]     region_slot,
  output logic              restore_off_write,
  output logic              boost_write,
  output logic              boost_value,
  output logic              table_full
);

  typedef enum logic [3:0] {
    S_IDLE, S_KREAD, S_KCMP, S_MISS, S_LOOKA, S_LOOKP, S_MUL, S_ADV, S_DECIDE, S_FINISH
  } state_t;

  state_t      state;
  thr_t        core_count, start_threads;
  logic        metric_mode;
  logic [31:0] switch_threshold;

  logic [63:0] key;
  logic [31:0] t_in, e_in;
  logic [SW-1:0] idx, a, p;
  logic [SW:0]   count;
  logic          a_new, prev_valid;
  logic [63:0]   prod;
  rec_t          ra, rp;
  logic          restore;

  thr_t          r_threads;
  logic [SW-1:0] r_slot;
  logic          r_restore, r_wr, r_val, r_full;

  logic [63:0] key_mem [REGION_SLOTS];
  rec_t        rec_mem [REGION_SLOTS];
  logic [63:0] key_rd;
  rec_t        rec_rd;

  logic          rec_we;
  logic [SW-1:0] rec_waddr, rec_raddr;
  rec_t          rec_wdata, init_rec, rp_next, ra_eff, ra_next;
  logic          adv_en, adv_restore, wr;
  thr_t          dec_threads;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    init_rec        = '0;
    init_rec.phase  = PH_START;
    init_rec.metric = metric_mode;
    init_rec.trial  = core_count;
  end

  // search step for the previous region
  always_comb begin
    logic [63:0] score;
    thr_t        st;
    score       = rp.metric ? prod : {32'd0, t_in};
    rp_next     = rp;
    adv_restore = 1'b0;
    st          = '0;
    if (rp.metric && prod == 64'd0) begin
      rp_next.phase  = PH_REPEAT;
      rp_next.metric = 1'b0;
    end
    case (rp_next.phase)
      PH_REPEAT: begin
        rp_next.phase = PH_S0;
        rp_next.trial = start_threads;
        rp_next.prev  = start_threads;
      end
      PH_S0: begin
        rp_next.score = score;
        rp_next.best  = rp_next.trial;
        rp_next.trial = sat_thr({rp_next.trial, 1'b0});
        rp_next.phase = PH_S1;
      end
      PH_S1: begin
        st = rp_next.prev >> 1;
        if (score < rp_next.score) begin
          rp_next.score = score;
          rp_next.best  = rp_next.trial;
          if ({rp_next.trial, 1'b0} <= {1'b0, core_count}) begin
            rp_next.prev  = rp_next.trial;
            rp_next.trial = sat_thr({rp_next.trial, 1'b0});
          end else begin
            rp_next.step = st;
            if (st >= thr_t'(2)) begin
              rp_next.trial = (rp_next.trial > st) ? rp_next.trial - st : '0;
              rp_next.phase = PH_S2;
            end else begin
              rp_next.boost = 1'b1;
              rp_next.toff  = t_in;
              rp_next.phase = PH_ENDT;
            end
          end
        end else if (rp_next.best == (core_count >> 1)) begin
          rp_next.boost = 1'b1;
          rp_next.toff  = t_in;
          rp_next.phase = PH_ENDT;
        end else begin
          rp_next.step = st;
          if (st >= thr_t'(2)) begin
            rp_next.trial = sat_thr({1'b0, rp_next.trial} + {1'b0, st});
            rp_next.phase = PH_S2;
          end else begin
            rp_next.boost = 1'b1;
            rp_next.toff  = t_in;
            rp_next.phase = PH_ENDT;
          end
        end
      end
      PH_S2: begin
        if (!(rp_next.score < score)) begin
          rp_next.best  = rp_next.trial;
          rp_next.score = score;
        end
        st           = rp_next.step >> 1;
        rp_next.step = st;
        if (st >= thr_t'(2)) begin
          rp_next.trial = sat_thr({1'b0, rp_next.trial} + {1'b0, st});
        end else begin
          rp_next.boost = 1'b1;
          rp_next.toff  = t_in;
          rp_next.phase = PH_ENDT;
        end
      end
      PH_ENDT: begin
        rp_next.phase = PH_END;
        rp_next.ton   = t_in;
        if (rp_next.score < score) begin
          rp_next.boost = 1'b0;
          adv_restore   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign adv_en = (rp.phase != PH_END) && (ra.phase != PH_START);

  // decision for the entered region; rp already holds the updated record
  always_comb begin
    ra_eff      = (a == p) ? rp : ra;
    ra_next     = ra_eff;
    wr          = 1'b0;
    dec_threads = ra_eff.trial;
    case (ra_eff.phase)
      PH_END: begin
        wr = (!rp.boost && ra_eff.boost &&
              ({1'b0, ra_eff.ton} + {1'b0, switch_threshold} < {1'b0, ra_eff.toff})) ||
             (rp.boost && !ra_eff.boost &&
              ({1'b0, ra_eff.toff} + {1'b0, switch_threshold} < {1'b0, ra_eff.ton}));
        dec_threads = ra_eff.best;
      end
      PH_ENDT: begin
        wr = (ra_eff.boost != rp.boost) && (ra_eff.toff > switch_threshold);
        dec_threads = ra_eff.best;
      end
      PH_START: begin
        ra_next.phase = PH_REPEAT;
        wr            = ra_eff.boost != rp.boost;
        dec_threads   = core_count;
      end
      default: begin
        wr = ra_eff.boost != rp.boost;
      end
    endcase
  end

  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = a;
    rec_wdata = ra_next;
    rec_raddr = (state == S_LOOKP) ? p : a;
    case (state)
      S_MISS: begin
        rec_we          = !prev_valid && (count != (SW+1)'(REGION_SLOTS));
        rec_waddr       = count[SW-1:0];
        rec_wdata       = init_rec;
        rec_wdata.phase = PH_REPEAT;
      end
      S_ADV: begin
        rec_we    = adv_en;
        rec_waddr = p;
        rec_wdata = rp_next;
      end
      S_DECIDE: rec_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    key_rd <= key_mem[idx];
    rec_rd <= rec_mem[rec_raddr];
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    if (state == S_MISS && count != (SW+1)'(REGION_SLOTS)) key_mem[count[SW-1:0]] <= key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      core_count       <= RST_CORE_COUNT;
      start_threads    <= RST_START;
      metric_mode      <= 1'b0;
      switch_threshold <= RST_THRESHOLD;
      count            <= '0;
      prev_valid       <= 1'b0;
      p                <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CORE_COUNT: core_count       <= cfg_data[CORE_BITS-1:0];
          REG_START:      start_threads    <= cfg_data[CORE_BITS-1:0];
          REG_METRIC:     metric_mode      <= cfg_data[0];
          REG_THRESHOLD:  switch_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key   <= region_key;
            t_in  <= elapsed_time;
            e_in  <= elapsed_energy;
            idx   <= '0;
            state <= (count == '0) ? S_MISS : S_KREAD;
          end
        end
        S_KREAD: state <= S_KCMP;
        S_KCMP: begin
          if (key_rd == key) begin
            a     <= idx;
            a_new <= 1'b0;
            state <= S_LOOKA;
          end else if ({1'b0, idx} + 1'b1 == count) begin
            state <= S_MISS;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_KREAD;
          end
        end
        S_MISS: begin
          if (count == (SW+1)'(REGION_SLOTS)) begin
            r_threads <= core_count;
            r_slot    <= '0;
            r_restore <= 1'b0;
            r_wr      <= 1'b0;
            r_val     <= 1'b0;
            r_full    <= 1'b1;
            state     <= S_FINISH;
          end else begin
            a     <= count[SW-1:0];
            a_new <= 1'b1;
            count <= count + 1'b1;
            if (!prev_valid) begin
              prev_valid <= 1'b1;
              p          <= count[SW-1:0];
              r_threads  <= core_count;
              r_slot     <= count[SW-1:0];
              r_restore  <= 1'b0;
              r_wr       <= 1'b0;
              r_val      <= 1'b0;
              r_full     <= 1'b0;
              state      <= S_FINISH;
            end else begin
              state <= S_LOOKA;
            end
          end
        end
        S_LOOKA: state <= S_LOOKP;
        S_LOOKP: begin
          ra    <= a_new ? init_rec : rec_rd;
          state <= S_MUL;
        end
        S_MUL: begin
          rp    <= rec_rd;
          prod  <= t_in * e_in;
          state <= S_ADV;
        end
        S_ADV: begin
          restore <= adv_en && adv_restore;
          if (adv_en) rp <= rp_next;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          p         <= a;
          r_threads <= dec_threads;
          r_slot    <= a;
          r_restore <= restore;
          r_wr      <= wr;
          r_val     <= wr && ra_next.boost;
          r_full    <= 1'b0;
          state     <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            thread_count      <= r_threads;
            region_slot       <= r_slot;
            restore_off_write <= r_restore;
            boost_write       <= r_wr;
            boost_value       <= r_val;
            table_full        <= r_full;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/rtcs_checker.sv
`include "region_thread_count_search_core_defines.svh"

module rtcs_checker
  import rtcs_pkg::*;
#(
  parameter int REGION_SLOTS = DEFAULT_SLOTS,
  localparam int SW = $clog2(REGION_SLOTS)
) (
  input logic              clk,
  input logic              rst,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [7:0]        cfg_index,
  input logic [31:0]       cfg_data,
  input logic              in_valid,
  input logic              in_ready,
  input logic [63:0]       region_key,
  input logic [31:0]       elapsed_time,
  input logic [31:0]       elapsed_energy,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CORE_BITS-1:0] thread_count,
  input logic [SW-1:0]     region_slot,
  input logic              restore_off_write,
  input logic              boost_write,
  input logic              boost_value,
  input logic              table_full
);

  `RTCS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(thread_count) && $stable(region_slot), "result dropped or changed while stalled")
  `RTCS_ASSERT_NOW(a_full_quiet, clk, rst, out_valid && table_full, !boost_write && !restore_off_write && region_slot == '0, "full table result carries requests")
  `RTCS_ASSERT_NOW(a_value_gated, clk, rst, out_valid && !boost_write, !boost_value, "boost value without write request")
  `RTCS_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "second request taken while busy")

endmodule

bind region_thread_count_search_core rtcs_checker #(.REGION_SLOTS(REGION_SLOTS)) u_rtcs_checker (.*);
